// ===== rtl/scpa_pkg.sv =====
// ============================================================================
// scpa_pkg: shared types and constants of the size-class pool allocator
// Request kinds as classified by the front end, result status codes, back-end
// sequencer states and the fixed address and queue dimensions.
// ============================================================================
`default_nettype none

package scpa_pkg;

    // Byte address width of the managed space.
    localparam int ADDR_W = 18;

    // Front-to-back queue: depth, pointer width, fill-level width.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;
    localparam int QUEUE_LW    = 3;

    // Request kind after classification.
    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_ZERO,
        OP_OVER
    } op_t;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ZERO     = 2'd1;
    localparam logic [1:0] ST_OVERSIZE = 2'd2;
    localparam logic [1:0] ST_NOPOOL   = 2'd3;

    // Back-end sequencer states.
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_EXEC,
        BK_POP
    } bk_state_t;

endpackage

`default_nettype wire

// ===== rtl/scpa_queue.sv =====
// ============================================================================
// scpa_queue: short FIFO between front end and back end
// Holds classified requests; reports its fill level so the front end can
// throttle new transfers.
// ============================================================================
`default_nettype none

module scpa_queue #(
    parameter int WIDTH = 40
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    input  wire logic [WIDTH-1:0]              wdata,
    input  wire logic                          pop,
    output logic      [WIDTH-1:0]              rdata,
    output logic                               empty,
    output logic      [scpa_pkg::QUEUE_LW-1:0] level
);

    logic [WIDTH-1:0]              ent_reg [scpa_pkg::QUEUE_DEPTH];
    logic [scpa_pkg::QUEUE_AW-1:0] wr_ptr_reg;
    logic [scpa_pkg::QUEUE_AW-1:0] rd_ptr_reg;
    logic [scpa_pkg::QUEUE_LW-1:0] level_reg;
    logic [scpa_pkg::QUEUE_LW-1:0] level_next;

    always_comb
    begin
        level_next = level_reg;
        if (push && !pop)
        begin
            level_next = level_reg + scpa_pkg::QUEUE_LW'(1);
        end
        else if (pop && !push)
        begin
            level_next = level_reg - scpa_pkg::QUEUE_LW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + scpa_pkg::QUEUE_AW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + scpa_pkg::QUEUE_AW'(1);
            end
            level_reg <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = ent_reg[rd_ptr_reg];
    assign empty = (level_reg == '0);
    assign level = level_reg;

endmodule

`default_nettype wire

// ===== rtl/scpa_front.sv =====
// ============================================================================
// scpa_front: request intake and classification
// Takes a request transfer, sorts out zero and oversize sizes, derives the
// size class and the link slot of the address, and pushes the result into
// the queue in the next cycle.
// ============================================================================
`default_nettype none

module scpa_front #(
    parameter int NUM_CLASSES = 16,
    parameter int CHUNK_STEP  = 8,
    parameter int CLS_W       = 4,
    parameter int LI_W        = 15
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic                          req_type,
    input  wire logic [15:0]                   req_size,
    input  wire logic [scpa_pkg::ADDR_W-1:0]   free_addr,
    input  wire logic [scpa_pkg::QUEUE_LW-1:0] q_level,
    output logic                               push,
    output scpa_pkg::op_t                      push_op,
    output logic      [CLS_W-1:0]              push_cls,
    output logic      [scpa_pkg::ADDR_W-1:0]   push_addr,
    output logic      [LI_W-1:0]               push_idx
);

    localparam int ADDR_W    = scpa_pkg::ADDR_W;
    localparam int MAX_CHUNK = NUM_CLASSES * CHUNK_STEP;
    localparam int STEP_L    = $clog2(CHUNK_STEP);
    // Class = (size - 1) / CHUNK_STEP through a reciprocal multiply.
    localparam int SZ_W      = $clog2(MAX_CHUNK);
    localparam int C_SH      = SZ_W + STEP_L;
    localparam int C_M       = ((1 << C_SH) + CHUNK_STEP - 1) / CHUNK_STEP;
    localparam int CP_W      = 2 * SZ_W + 1;
    localparam logic [CP_W-1:0] C_MV = CP_W'(C_M);
    // Link slot = addr / CHUNK_STEP, split into two half-width products.
    localparam int L_SH      = ADDR_W + STEP_L;
    localparam int L_M       = ((1 << L_SH) + CHUNK_STEP - 1) / CHUNK_STEP;
    localparam int HALF      = ADDR_W / 2;
    localparam int PP_W      = ADDR_W + 1 + HALF;
    localparam int SUM_W     = 2 * ADDR_W + 1;
    localparam logic [PP_W-1:0] L_MV = PP_W'(L_M);
    localparam int OCC_W     = scpa_pkg::QUEUE_LW + 1;

    logic                  accept;
    logic [SZ_W-1:0]       size_m1;
    logic [CP_W-1:0]       cls_prod;
    scpa_pkg::op_t         op;
    logic [OCC_W-1:0]      occ;
    logic [SUM_W-1:0]      idx_sum;

    logic                  s1_valid_reg;
    scpa_pkg::op_t         s1_op_reg;
    logic [CLS_W-1:0]      s1_cls_reg;
    logic [ADDR_W-1:0]     s1_addr_reg;
    logic [PP_W-1:0]       s1_plo_reg;
    logic [PP_W-1:0]       s1_phi_reg;

    // In-flight items count against queue space.
    assign occ    = OCC_W'(q_level) + OCC_W'(s1_valid_reg);
    assign busy   = (occ >= OCC_W'(scpa_pkg::QUEUE_DEPTH));
    assign accept = start && !busy;

    assign size_m1  = SZ_W'(req_size - 16'd1);
    assign cls_prod = CP_W'(size_m1) * C_MV;

    always_comb
    begin
        if (req_size == 16'd0)
        begin
            op = scpa_pkg::OP_ZERO;
        end
        else if (req_size > 16'(MAX_CHUNK))
        begin
            op = scpa_pkg::OP_OVER;
        end
        else if (req_type)
        begin
            op = scpa_pkg::OP_FREE;
        end
        else
        begin
            op = scpa_pkg::OP_ALLOC;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg   <= op;
            s1_cls_reg  <= CLS_W'(cls_prod >> C_SH);
            s1_addr_reg <= free_addr;
            s1_plo_reg  <= PP_W'(free_addr[HALF-1:0]) * L_MV;
            s1_phi_reg  <= PP_W'(free_addr[ADDR_W-1:HALF]) * L_MV;
        end
    end

    assign idx_sum   = (SUM_W'(s1_phi_reg) << HALF) + SUM_W'(s1_plo_reg);
    assign push      = s1_valid_reg;
    assign push_op   = s1_op_reg;
    assign push_cls  = s1_cls_reg;
    assign push_addr = s1_addr_reg;
    assign push_idx  = LI_W'(idx_sum >> L_SH);

endmodule

`default_nettype wire

// ===== rtl/scpa_back.sv =====
// ============================================================================
// scpa_back: allocation engine
// Pops classified requests, runs the class table and link memory read-modify-
// write, carves pools, and drives the one-cycle result strobe.
// ============================================================================
`default_nettype none

module scpa_back #(
    parameter int NUM_CLASSES = 16,
    parameter int CHUNK_STEP  = 8,
    parameter int POOL_BYTES  = 4096,
    parameter int MAX_POOLS   = 64,
    parameter int CLS_W       = 4,
    parameter int LI_W        = 15
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        q_empty,
    input  scpa_pkg::op_t                    q_op,
    input  wire logic [CLS_W-1:0]            q_cls,
    input  wire logic [scpa_pkg::ADDR_W-1:0] q_addr,
    input  wire logic [LI_W-1:0]             q_idx,
    output logic                             q_pop,
    output logic                             done,
    output logic      [scpa_pkg::ADDR_W-1:0] chunk_addr,
    output logic      [1:0]                  status
);

    localparam int ADDR_W     = scpa_pkg::ADDR_W;
    localparam int LINK_DEPTH = ((1 << ADDR_W) + CHUNK_STEP - 1) / CHUNK_STEP;
    localparam int LEFT_W     = $clog2(POOL_BYTES / CHUNK_STEP);
    localparam int PU_W       = $clog2(MAX_POOLS + 1);
    // Class entry: {head addr, head link slot, carve pointer, chunks left}
    localparam int CM_W       = 2 * ADDR_W + LI_W + LEFT_W;
    // Link entry: {valid, next addr, next link slot}
    localparam int LK_W       = 1 + ADDR_W + LI_W;
    localparam logic [ADDR_W-1:0] STEP_A = ADDR_W'(CHUNK_STEP);
    localparam logic [ADDR_W-1:0] POOL_A = ADDR_W'(POOL_BYTES);

    logic [LEFT_W-1:0]      nleft_tbl [NUM_CLASSES];

    logic [CM_W-1:0]        class_mem_reg [NUM_CLASSES];
    logic [LK_W-1:0]        link_mem_reg  [LINK_DEPTH];

    scpa_pkg::bk_state_t    state_reg;
    scpa_pkg::bk_state_t    state_next;
    logic [NUM_CLASSES-1:0] head_valid_reg;
    logic [NUM_CLASSES-1:0] carve_valid_reg;
    logic [PU_W-1:0]        pools_used_reg;
    logic                   done_reg;

    scpa_pkg::op_t          cur_op_reg;
    logic [CLS_W-1:0]       cur_cls_reg;
    logic [ADDR_W-1:0]      cur_addr_reg;
    logic [LI_W-1:0]        cur_idx_reg;
    logic [CM_W-1:0]        cm_rd_reg;
    logic [LK_W-1:0]        lk_rd_reg;
    logic [ADDR_W-1:0]      chunk_addr_reg;
    logic [1:0]             status_reg;

    logic [ADDR_W-1:0]      rd_head;
    logic [LI_W-1:0]        rd_hidx;
    logic [ADDR_W-1:0]      rd_ptr;
    logic [LEFT_W-1:0]      rd_left;
    logic                   hv;
    logic                   cv;
    logic [ADDR_W-1:0]      csize;
    logic [ADDR_W-1:0]      base;

    logic                   cm_re;
    logic                   cm_we;
    logic [CM_W-1:0]        cm_wdata;
    logic                   lk_re;
    logic                   lk_we;
    logic [LK_W-1:0]        lk_wdata;
    logic                   hv_we;
    logic                   hv_val;
    logic                   cv_we;
    logic                   pools_inc;
    logic                   res_valid;
    logic [ADDR_W-1:0]      res_addr;
    logic [1:0]             res_status;

    // Chunks remaining after the first one when a class opens a fresh pool.
    for (genvar k = 0; k < NUM_CLASSES; k++)
    begin : g_nleft
        localparam int NCH = POOL_BYTES / ((k + 1) * CHUNK_STEP);
        assign nleft_tbl[k] = LEFT_W'((NCH > 0) ? NCH - 1 : 0);
    end

    assign rd_head = cm_rd_reg[CM_W-1 -: ADDR_W];
    assign rd_hidx = cm_rd_reg[LI_W+ADDR_W+LEFT_W-1 -: LI_W];
    assign rd_ptr  = cm_rd_reg[ADDR_W+LEFT_W-1 -: ADDR_W];
    assign rd_left = cm_rd_reg[LEFT_W-1:0];
    assign hv      = head_valid_reg[cur_cls_reg];
    assign cv      = carve_valid_reg[cur_cls_reg];
    assign csize   = (ADDR_W'(cur_cls_reg) + ADDR_W'(1)) * STEP_A;
    assign base    = ADDR_W'(pools_used_reg) * POOL_A;

    always_comb
    begin
        state_next = state_reg;
        q_pop      = 1'b0;
        cm_re      = 1'b0;
        cm_we      = 1'b0;
        cm_wdata   = {rd_head, rd_hidx, rd_ptr, rd_left};
        lk_re      = 1'b0;
        lk_we      = 1'b0;
        lk_wdata   = {hv, rd_head, rd_hidx};
        hv_we      = 1'b0;
        hv_val     = 1'b0;
        cv_we      = 1'b0;
        pools_inc  = 1'b0;
        res_valid  = 1'b0;
        res_addr   = '0;
        res_status = scpa_pkg::ST_OK;
        unique case (state_reg)
            scpa_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    cm_re = 1'b1;
                    if (q_op == scpa_pkg::OP_ZERO)
                    begin
                        res_valid  = 1'b1;
                        res_status = scpa_pkg::ST_ZERO;
                    end
                    else if (q_op == scpa_pkg::OP_OVER)
                    begin
                        res_valid  = 1'b1;
                        res_status = scpa_pkg::ST_OVERSIZE;
                    end
                    else
                    begin
                        state_next = scpa_pkg::BK_EXEC;
                    end
                end
            end
            scpa_pkg::BK_EXEC:
            begin
                state_next = scpa_pkg::BK_IDLE;
                if (cur_op_reg == scpa_pkg::OP_FREE)
                begin
                    // push: old head becomes the freed chunk's link
                    lk_we     = 1'b1;
                    cm_we     = 1'b1;
                    cm_wdata  = {cur_addr_reg, cur_idx_reg, rd_ptr, rd_left};
                    hv_we     = 1'b1;
                    hv_val    = 1'b1;
                    res_valid = 1'b1;
                end
                else if (hv)
                begin
                    lk_re      = 1'b1;
                    state_next = scpa_pkg::BK_POP;
                end
                else if (cv && (rd_left != '0))
                begin
                    cm_we     = 1'b1;
                    cm_wdata  = {rd_head, rd_hidx, rd_ptr + csize,
                                 rd_left - LEFT_W'(1)};
                    res_valid = 1'b1;
                    res_addr  = rd_ptr;
                end
                else if (pools_used_reg >= PU_W'(MAX_POOLS))
                begin
                    res_valid  = 1'b1;
                    res_status = scpa_pkg::ST_NOPOOL;
                end
                else
                begin
                    cm_we     = 1'b1;
                    cm_wdata  = {rd_head, rd_hidx, base + csize, nleft_tbl[cur_cls_reg]};
                    cv_we     = 1'b1;
                    pools_inc = 1'b1;
                    res_valid = 1'b1;
                    res_addr  = base;
                end
            end
            scpa_pkg::BK_POP:
            begin
                state_next = scpa_pkg::BK_IDLE;
                cm_we      = 1'b1;
                cm_wdata   = {lk_rd_reg[LK_W-2:0], rd_ptr, rd_left};
                hv_we      = 1'b1;
                hv_val     = lk_rd_reg[LK_W-1];
                res_valid  = 1'b1;
                res_addr   = rd_head;
            end
            default:
            begin
                state_next = scpa_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= scpa_pkg::BK_IDLE;
            head_valid_reg  <= '0;
            carve_valid_reg <= '0;
            pools_used_reg  <= '0;
            done_reg        <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= res_valid;
            if (hv_we)
            begin
                head_valid_reg[cur_cls_reg] <= hv_val;
            end
            if (cv_we)
            begin
                carve_valid_reg[cur_cls_reg] <= 1'b1;
            end
            if (pools_inc)
            begin
                pools_used_reg <= pools_used_reg + PU_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_op_reg   <= q_op;
            cur_cls_reg  <= q_cls;
            cur_addr_reg <= q_addr;
            cur_idx_reg  <= q_idx;
        end
        if (res_valid)
        begin
            chunk_addr_reg <= res_addr;
            status_reg     <= res_status;
        end
    end

    // Class table: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cm_we)
        begin
            class_mem_reg[cur_cls_reg] <= cm_wdata;
        end
        if (cm_re)
        begin
            cm_rd_reg <= class_mem_reg[q_cls];
        end
    end

    // Link memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (lk_we)
        begin
            link_mem_reg[cur_idx_reg] <= lk_wdata;
        end
        if (lk_re)
        begin
            lk_rd_reg <= link_mem_reg[rd_hidx];
        end
    end

    assign done       = done_reg;
    assign chunk_addr = chunk_addr_reg;
    assign status     = status_reg;

endmodule

`default_nettype wire

// ===== rtl/size_class_pool_allocator.sv =====
// ============================================================================
// size_class_pool_allocator: segregated free-list pool allocator
// Allocates and frees fixed-size chunks per size class out of equal pools,
// with LIFO free lists and lazy carving of freshly opened pools.
// ============================================================================
//
//  channel   handshake             payload
//  -------   -------------------   -----------------------------------------
//  request   start & !busy         req_type, req_size, free_addr
//  result    done (1-cycle pulse)  chunk_addr, status
//
//  The front end registers and classifies a request, pushing it into a
//  4-entry queue on the next cycle; busy rises once queued plus in-flight
//  requests fill it. The back end answers zero or oversize requests from
//  its idle state; a free, a carve, a new pool or an out-of-pools reply
//  also passes the execute state, and a free-list pop goes on to the pop
//  state (class table read, link memory read, write-back); the registered
//  class table and link memory reads set that pace. done is registered and
//  follows in the cycle after the back end finishes.
//  Reset empties all lists and pools at once; no clearing pass is needed.
//  Results cannot be stalled: each transfer is valid for the done cycle only.
//
`default_nettype none

module size_class_pool_allocator #(
    parameter int NUM_CLASSES = 16,
    parameter int CHUNK_STEP  = 8,
    parameter int POOL_BYTES  = 4096,
    parameter int MAX_POOLS   = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        req_type,
    input  wire logic [15:0]                 req_size,
    input  wire logic [scpa_pkg::ADDR_W-1:0] free_addr,
    output logic                             done,
    output logic      [scpa_pkg::ADDR_W-1:0] chunk_addr,
    output logic      [1:0]                  status
);

    localparam int ADDR_W     = scpa_pkg::ADDR_W;
    localparam int LINK_DEPTH = ((1 << ADDR_W) + CHUNK_STEP - 1) / CHUNK_STEP;
    localparam int LI_W       = $clog2(LINK_DEPTH);
    localparam int CLS_W      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    // Queue entry: {kind, class, address, link slot}
    localparam int QW         = 2 + CLS_W + ADDR_W + LI_W;

    logic [scpa_pkg::QUEUE_LW-1:0] q_level;
    logic                          push;
    scpa_pkg::op_t                 push_op;
    logic [CLS_W-1:0]              push_cls;
    logic [ADDR_W-1:0]             push_addr;
    logic [LI_W-1:0]               push_idx;
    logic [QW-1:0]                 q_wdata;
    logic [QW-1:0]                 q_rdata;
    logic                          q_empty;
    logic                          q_pop;

    scpa_front #(
        .NUM_CLASSES (NUM_CLASSES),
        .CHUNK_STEP  (CHUNK_STEP),
        .CLS_W       (CLS_W),
        .LI_W        (LI_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req_type  (req_type),
        .req_size  (req_size),
        .free_addr (free_addr),
        .q_level   (q_level),
        .push      (push),
        .push_op   (push_op),
        .push_cls  (push_cls),
        .push_addr (push_addr),
        .push_idx  (push_idx)
    );

    assign q_wdata = {push_op, push_cls, push_addr, push_idx};

    scpa_queue #(
        .WIDTH (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (q_wdata),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty),
        .level (q_level)
    );

    scpa_back #(
        .NUM_CLASSES (NUM_CLASSES),
        .CHUNK_STEP  (CHUNK_STEP),
        .POOL_BYTES  (POOL_BYTES),
        .MAX_POOLS   (MAX_POOLS),
        .CLS_W       (CLS_W),
        .LI_W        (LI_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (q_empty),
        .q_op       (scpa_pkg::op_t'(q_rdata[QW-1 -: 2])),
        .q_cls      (q_rdata[QW-3 -: CLS_W]),
        .q_addr     (q_rdata[ADDR_W+LI_W-1 -: ADDR_W]),
        .q_idx      (q_rdata[LI_W-1:0]),
        .q_pop      (q_pop),
        .done       (done),
        .chunk_addr (chunk_addr),
        .status     (status)
    );

endmodule

`default_nettype wire

// ===== bench/size_class_pool_allocator_checker.sv =====
// ============================================================================
// size_class_pool_allocator_checker: result predictor and comparator
// Watches request and result transfers of the allocator. It keeps its own
// copy of the free lists, carve pointers and pool count, and predicts each
// result. It then compares status and chunk address in order.
// ============================================================================

module size_class_pool_allocator_checker #(
    parameter int NUM_CLASSES = 16,
    parameter int CHUNK_STEP  = 8,
    parameter int POOL_BYTES  = 4096,
    parameter int MAX_POOLS   = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic                        busy,
    input  wire logic                        req_type,
    input  wire logic [15:0]                 req_size,
    input  wire logic [scpa_pkg::ADDR_W-1:0] free_addr,
    input  wire logic                        done,
    input  wire logic [scpa_pkg::ADDR_W-1:0] chunk_addr,
    input  wire logic [1:0]                  status,
    output int                               outstanding,
    output int                               mismatches
);

    localparam int ADDR_W    = scpa_pkg::ADDR_W;
    localparam int MAX_PRINT = 40;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [1:0]        status;
        int                seq;
    } alloc_result_t;

    // bit ADDR_W marks a non-empty list / a valid link
    logic [ADDR_W:0]   list_head   [NUM_CLASSES];
    logic [ADDR_W:0]   chunk_link  [int unsigned];
    logic [ADDR_W-1:0] carve_next  [NUM_CLASSES];
    int unsigned       carve_count [NUM_CLASSES];
    int unsigned       pools_opened;
    alloc_result_t     pending_results[$];
    int                req_seq;

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINT)
            $display("%0t: MISMATCH %s", $time, msg);
    endtask

    // Applies one request to the shadow state; returns what the block owes.
    function automatic alloc_result_t predict_request(
        input logic              is_free,
        input logic [15:0]       size,
        input logic [ADDR_W-1:0] faddr
    );
        alloc_result_t     r;
        int unsigned       cls;
        int unsigned       csize;
        int unsigned       nchunks;
        logic [ADDR_W-1:0] base;
        r.addr   = '0;
        r.status = scpa_pkg::ST_OK;
        r.seq    = 0;
        if (size == 0)
            r.status = scpa_pkg::ST_ZERO;
        else if (size > NUM_CLASSES * CHUNK_STEP)
            r.status = scpa_pkg::ST_OVERSIZE;
        else
        begin
            cls   = (size + CHUNK_STEP - 1) / CHUNK_STEP - 1;
            csize = (cls + 1) * CHUNK_STEP;
            if (is_free)
            begin
                chunk_link[faddr / CHUNK_STEP] = list_head[cls];
                list_head[cls] = {1'b1, faddr};
            end
            else if (list_head[cls][ADDR_W])
            begin
                r.addr = list_head[cls][ADDR_W-1:0];
                list_head[cls] = chunk_link[r.addr / CHUNK_STEP];
            end
            else if (carve_count[cls] != 0)
            begin
                r.addr = carve_next[cls];
                carve_next[cls] = ADDR_W'(carve_next[cls] + csize);
                carve_count[cls]--;
            end
            else if (pools_opened >= MAX_POOLS)
                r.status = scpa_pkg::ST_NOPOOL;
            else
            begin
                base    = ADDR_W'(pools_opened * POOL_BYTES);
                nchunks = POOL_BYTES / csize;
                pools_opened++;
                carve_next[cls]  = ADDR_W'(base + csize);
                carve_count[cls] = (nchunks > 0) ? nchunks - 1 : 0;
                r.addr = base;
            end
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                list_head[i]   = '0;
                carve_next[i]  = '0;
                carve_count[i] = 0;
            end
            chunk_link.delete();
            pending_results.delete();
            pools_opened = 0;
            req_seq      = 0;
            mismatches   = 0;
            outstanding <= 0;
        end
        else
        begin
            // results first, so a result is never matched to a request of the same edge
            if (done)
            begin
                if (pending_results.size() == 0)
                    report_mismatch($sformatf(
                        "result with nothing expected: addr 0x%05h status %0d",
                        chunk_addr, status));
                else
                begin
                    want = pending_results.pop_front();
                    if (status !== want.status)
                        report_mismatch($sformatf(
                            "request %0d: status %0d, expected %0d",
                            want.seq, status, want.status));
                    if (chunk_addr !== want.addr)
                        report_mismatch($sformatf(
                            "request %0d: chunk_addr 0x%05h, expected 0x%05h",
                            want.seq, chunk_addr, want.addr));
                end
            end
            if (start && !busy)
            begin
                want = predict_request(req_type, req_size, free_addr);
                want.seq = req_seq++;
                pending_results.push_back(want);
            end
            outstanding <= pending_results.size();
        end
    end

endmodule

// ===== bench/size_class_pool_allocator_tb.sv =====
// ============================================================================
// size_class_pool_allocator_tb: testbench top of the pool allocator
// Drives directed and random allocate/free traffic with varying sender gaps
// and reports the verdict from the checker's count.
// ============================================================================

module size_class_pool_allocator_tb;

    localparam int ADDR_W      = scpa_pkg::ADDR_W;
    localparam int NUM_CLASSES = 16;
    localparam int CHUNK_STEP  = 8;
    localparam int POOL_BYTES  = 4096;
    localparam int MAX_POOLS   = 64;
    localparam int MAX_CHUNK   = NUM_CLASSES * CHUNK_STEP;

    // req_type encoding
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    localparam int RANDOM_ITEMS    = 630;
    localparam int TAIL_ITEMS      = 40;
    localparam int END_DRAIN_LIMIT = 2000;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              req_type;
    logic [15:0]       req_size;
    logic [ADDR_W-1:0] free_addr;
    logic              done;
    logic [ADDR_W-1:0] chunk_addr;
    logic [1:0]        status;
    int                outstanding;
    int                mismatches;

    typedef struct {
        logic        kind;
        logic [15:0] size;
    } sent_req_t;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [15:0]       size;
    } live_chunk_t;

    sent_req_t   in_flight[$];     // requests whose result is still to come
    live_chunk_t live_chunks[$];   // chunks handed out and not yet freed
    int          idle_pct = 0;     // sender gap probability per cycle, in percent

    // sender gap per random phase: none, heavy, moderate
    int n_phase_pct[3] = '{0, 68, 37};

    int n_alloc  = 0;
    int n_free   = 0;
    int n_zero   = 0;
    int n_over   = 0;
    int n_nopool = 0;

    size_class_pool_allocator #(
        .NUM_CLASSES (NUM_CLASSES),
        .CHUNK_STEP  (CHUNK_STEP),
        .POOL_BYTES  (POOL_BYTES),
        .MAX_POOLS   (MAX_POOLS)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req_type   (req_type),
        .req_size   (req_size),
        .free_addr  (free_addr),
        .done       (done),
        .chunk_addr (chunk_addr),
        .status     (status)
    );

    size_class_pool_allocator_checker #(
        .NUM_CLASSES (NUM_CLASSES),
        .CHUNK_STEP  (CHUNK_STEP),
        .POOL_BYTES  (POOL_BYTES),
        .MAX_POOLS   (MAX_POOLS)
    ) alloc_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .req_size    (req_size),
        .free_addr   (free_addr),
        .done        (done),
        .chunk_addr  (chunk_addr),
        .status      (status),
        .outstanding (outstanding),
        .mismatches  (mismatches)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Stimulus side only: remember which chunks came back so that most frees
    // return real allocations. Checking is left entirely to the checker.
    always @(posedge clk)
    begin
        sent_req_t r;
        if (rst_n)
        begin
            if (done && in_flight.size() != 0)
            begin
                r = in_flight.pop_front();
                if (status == scpa_pkg::ST_NOPOOL)
                    n_nopool++;
                if (r.kind == REQ_ALLOC && status == scpa_pkg::ST_OK)
                    live_chunks.push_back('{chunk_addr, r.size});
            end
            if (start && !busy)
                in_flight.push_back('{req_type, req_size});
        end
    end

    // One request transfer. Called right after a rising edge; returns at the
    // edge where the request was taken, with start still high so that
    // back-to-back requests need no gap.
    task automatic issue(input logic kind, input logic [15:0] size,
                         input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start     <= 1'b1;
        req_type  <= kind;
        req_size  <= size;
        free_addr <= addr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (size == 0)
            n_zero++;
        else if (size > MAX_CHUNK)
            n_over++;
        else if (kind == REQ_FREE)
            n_free++;
        else
            n_alloc++;
    endtask

    // Sender holds off until every outstanding result has been seen.
    task automatic wait_all_results();
        start <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    function automatic logic [ADDR_W-1:0] any_addr();
        return ADDR_W'($urandom_range((1 << ADDR_W) - 1));
    endfunction

    // Another size that maps to the same class as the given one.
    function automatic logic [15:0] same_class_size(input logic [15:0] size);
        int cls;
        cls = (size + CHUNK_STEP - 1) / CHUNK_STEP - 1;
        return 16'(cls * CHUNK_STEP + $urandom_range(1, CHUNK_STEP));
    endfunction

    // Mostly allocate/free pairs over live chunks; the rest is foreign frees
    // (aligned or not), zero sizes and oversize requests of either kind.
    task automatic random_request();
        int                roll;
        int                pick;
        live_chunk_t       c;
        logic [ADDR_W-1:0] a;
        roll = $urandom_range(99);
        if (roll < 45)
            issue(REQ_ALLOC, 16'($urandom_range(1, MAX_CHUNK)), any_addr());
        else if (roll < 80 && live_chunks.size() != 0)
        begin
            pick = $urandom_range(live_chunks.size() - 1);
            c = live_chunks[pick];
            live_chunks.delete(pick);
            issue(REQ_FREE, same_class_size(c.size), c.addr);
        end
        else if (roll < 88)
        begin
            a = any_addr();
            if ($urandom_range(1))
                a = ADDR_W'(a - a % CHUNK_STEP);
            issue(REQ_FREE, 16'($urandom_range(1, MAX_CHUNK)), a);
        end
        else if (roll < 94)
            issue(1'($urandom_range(1)), 16'd0, any_addr());
        else
            issue(1'($urandom_range(1)),
                  16'($urandom_range(MAX_CHUNK + 1, 16'hFFFF)), any_addr());
    endtask

    initial
    begin
        int wait_cycles;
        int n;
        rst_n     <= 1'b0;
        start     <= 1'b0;
        req_type  <= REQ_ALLOC;
        req_size  <= '0;
        free_addr <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: fresh pools, carving, special sizes, LIFO reuse ----
        issue(REQ_ALLOC, 16'd1,      18'h00000);   // class 0 opens pool 0
        issue(REQ_ALLOC, 16'd8,      18'h3FFFF);   // carved next chunk
        issue(REQ_ALLOC, 16'd9,      18'h00000);   // class 1 opens a pool
        issue(REQ_ALLOC, 16'd128,    18'h00000);   // largest class
        issue(REQ_ALLOC, 16'd121,    18'h00000);
        issue(REQ_ALLOC, 16'd0,      18'h00000);   // zero size allocate
        issue(REQ_FREE,  16'd0,      18'h3FFFF);   // zero size free
        issue(REQ_ALLOC, 16'd129,    18'h00000);   // just over the largest class
        issue(REQ_FREE,  16'hFFFF,   18'h2AAAA);   // oversize free
        issue(REQ_ALLOC, 16'hFFFF,   18'h15555);   // oversize allocate
        issue(REQ_FREE,  16'd8,      18'h00000);
        issue(REQ_FREE,  16'd1,      18'h00008);
        issue(REQ_ALLOC, 16'd5,      18'h00000);   // pops last freed first
        issue(REQ_ALLOC, 16'd8,      18'h00000);
        issue(REQ_ALLOC, 16'd3,      18'h00000);   // list empty again: carve
        // two foreign frees sharing one link slot: the second overwrites the
        // first one's link, so the list points back at itself
        issue(REQ_FREE,  16'd128,    18'h3FFFF);
        issue(REQ_FREE,  16'd125,    18'h3FFF8);
        issue(REQ_ALLOC, 16'd128,    18'h00000);
        issue(REQ_ALLOC, 16'd128,    18'h00000);
        // a class 0 free into the same slot ends the self-loop
        issue(REQ_FREE,  16'd8,      18'h3FFF8);
        issue(REQ_ALLOC, 16'd128,    18'h00000);
        issue(REQ_ALLOC, 16'd1,      18'h00000);
        issue(REQ_ALLOC, 16'd120,    18'h00000);
        wait_all_results();
        // only real chunks from here on
        live_chunks.delete();

        // ---- random traffic in three idle phases, drained between them ----
        foreach (n_phase_pct[p])
        begin
            idle_pct = n_phase_pct[p];
            for (n = 0; n < RANDOM_ITEMS / 3; n++)
                random_request();
            wait_all_results();
        end

        // closing stretch with the sender mostly idle
        idle_pct = 68;
        for (n = 0; n < TAIL_ITEMS; n++)
            random_request();

        // ---- end: let the last results arrive, then look for strays ----
        start <= 1'b0;
        wait_cycles = 0;
        do
        begin
            @(posedge clk);
            wait_cycles++;
        end
        while (outstanding != 0 && wait_cycles < END_DRAIN_LIMIT);
        repeat (10) @(posedge clk);

        if (outstanding != 0)
            $display("%0d expected results never arrived", outstanding);
        $display("Covered %0d allocates, %0d frees, %0d zero-size, %0d oversize requests",
                 n_alloc, n_free, n_zero, n_over);
        $display("%0d allocates hit the pool limit; %0d mismatches", n_nopool, mismatches);
        if (mismatches == 0 && outstanding == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout waiting for the allocator");
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/scpa_pkg.sv
rtl/scpa_queue.sv
rtl/scpa_front.sv
rtl/scpa_back.sv
rtl/size_class_pool_allocator.sv
bench/size_class_pool_allocator_checker.sv
bench/size_class_pool_allocator_tb.sv
